[sv/skinf_pkg.sv]
`timescale 1ns / 1ps
// Package for the skin influence table: transaction types, op codes,
// controller states and the command/status bundles. No dependencies.
package skinf_pkg;

	localparam int VID_W     = 12;
	localparam int IN_JNT_W  = 8;
	localparam int IN_WGT_W  = 16;
	localparam int WEIGHT_W  = 20;
	localparam int FRAC_W    = 16;
	localparam int Q_BITS    = 17;              // normalised weight is at most 65536
	localparam int BITCNT_W  = 5;
	localparam int NUM_W     = WEIGHT_W + FRAC_W + 1;
	localparam int SHOWN     = 4;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_NORM  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
	localparam logic [31:0]         COUNT_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]          op;
		logic [VID_W-1:0]    vertex_id;
		logic [IN_JNT_W-1:0] joint;
		logic [IN_WGT_W-1:0] weight;
	} item_t;

	typedef struct packed {
		logic                evicted_or_dropped;
		logic                bad_total;
		logic [31:0]         discard_total;
		logic [7:0]          joint_a;
		logic [7:0]          joint_b;
		logic [7:0]          joint_c;
		logic [7:0]          joint_d;
		logic [WEIGHT_W-1:0] weight_a;
		logic [WEIGHT_W-1:0] weight_b;
		logic [WEIGHT_W-1:0] weight_c;
		logic [WEIGHT_W-1:0] weight_d;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_WB
	} state_t;

	typedef struct packed {
		logic clr_write;
		logic accept;
		logic exec;
		logic norm_load;
		logic sum_step;
		logic div_init;
		logic div_step;
		logic div_store;
		logic norm_write;
		logic bad_emit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_norm;
		logic slot_last;
		logic total_zero;
		logic div_last;
	} sts_t;

endpackage

[sv/skin_influence_top4_normalize.sv]
`timescale 1ns / 1ps
// Skin influence table, top level: up to SLOTS joint/weight pairs per vertex
// with add, normalise and clear operations. Depends on skinf_pkg, skinf_ctrl,
// skinf_dp (and through it skinf_ram).
//
// Usage:
//  - Input channel: a transaction is taken on a rising edge with start high
//    and busy low; item carries op, vertex_id, joint and weight.
//  - Result channel: exactly one result per transaction, held on result for
//    one cycle with done high. There is no back-pressure: the receiver must
//    take it in that cycle.
//  - Add, clear, unused op and out-of-range vertex: one vertex RAM read, then
//    the add merge or the clear, written back if in range; done is high in the
//    cycle busy drops, and a new transaction may be given then.
//  - Normalise: a summing pass, then the shared bit-serial divider, 17
//    quotient bits per slot; a zero total ends after the sum with bad_total
//    set.
//  - Reset: asynchronous, arst_n low. Afterwards a clearing pass writes zero
//    to every vertex row, with busy held high.
module skin_influence_top4_normalize
	import skinf_pkg::*;
#(
	parameter int VERTEX_COUNT = 4096,
	parameter int JOINT_BITS   = 8,
	parameter int SLOTS        = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output result_t result,
	output logic    done
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: clear pass, RMW, normalise loop
	skinf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table, merge logic, divider, result register
	skinf_dp #(
		.VERTEX_COUNT (VERTEX_COUNT),
		.JOINT_BITS   (JOINT_BITS),
		.SLOTS        (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.item   (item),
		.result (result),
		.done   (done)
	);

`ifndef SYNTHESIS
	// an accepted transaction keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after accepting a transaction");

	// every result follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	// results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");
`endif

endmodule

[sv/skinf_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skinf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/skinf_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the skin influence table: sequences the clearing pass,
// table read-modify-write and the normalise loop. Depends on skinf_pkg.
module skinf_ctrl
	import skinf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.is_norm) begin
					cmd.norm_load = 1'b1;
					state_d       = ST_SUM;
				end else begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.slot_last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (sts.total_zero) begin
					cmd.bad_emit = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.div_store = 1'b1;
					state_d       = sts.slot_last ? ST_WB : ST_PREP;
				end
			end
			ST_WB: begin
				cmd.norm_write = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[sv/skinf_dp.sv]
`timescale 1ns / 1ps
// Datapath for the skin influence table: vertex RAM, add/merge logic,
// bit-serial normalise divider, discard counter, result register.
// Depends on skinf_pkg and skinf_ram.
module skinf_dp
	import skinf_pkg::*;
#(
	parameter int VERTEX_COUNT = 4096,
	parameter int JOINT_BITS   = 8,
	parameter int SLOTS        = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output sts_t    sts,
	input  item_t   item,
	output result_t result,
	output logic    done
);

	localparam int VA    = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int SW    = JOINT_BITS + WEIGHT_W;
	localparam int RW    = SLOTS * SW;
	localparam int SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TOT_W = WEIGHT_W + ((SLOTS > 1) ? $clog2(SLOTS) : 0);

	// captured transaction
	item_t           item_q;
	logic [VA-1:0]   addr_q;
	logic            inr_q;
	logic [VA-1:0]   clr_q;

	logic [VA+VID_W-1:0] vext;
	logic [VA-1:0]       addr_in;
	logic                inr_in;

	assign vext    = (VA + VID_W)'(item.vertex_id);
	assign addr_in = vext[VA-1:0];
	assign inr_in  = 32'(item.vertex_id) < 32'(VERTEX_COUNT);

	// RAM
	logic          we;
	logic [VA-1:0] waddr;
	logic [RW-1:0] wdata;
	logic [RW-1:0] rdata;

	skinf_ram #(.WIDTH(RW), .DEPTH(VERTEX_COUNT)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.accept),
		.raddr (addr_in),
		.rdata (rdata)
	);

	logic [JOINT_BITS-1:0] rd_j [SLOTS];
	logic [WEIGHT_W-1:0]   rd_w [SLOTS];

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			rd_w[k] = rdata[k*SW +: WEIGHT_W];
			rd_j[k] = rdata[k*SW + WEIGHT_W +: JOINT_BITS];
		end
	end

	// add / merge
	logic [JOINT_BITS+IN_JNT_W-1:0] jext;
	logic [JOINT_BITS-1:0]          jnt;
	logic [WEIGHT_W-1:0]            wnew;
	logic                           hit;
	logic [SI_W-1:0]                hidx, lidx;
	logic [WEIGHT_W-1:0]            minw;
	logic [WEIGHT_W:0]              sumw;
	logic                           add_drop;
	logic [JOINT_BITS-1:0]          aj [SLOTS];
	logic [WEIGHT_W-1:0]            aw [SLOTS];

	assign jext = (JOINT_BITS + IN_JNT_W)'(item_q.joint);
	assign jnt  = jext[JOINT_BITS-1:0];
	assign wnew = WEIGHT_W'(item_q.weight);

	always_comb begin
		hit  = 1'b0;
		hidx = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (rd_w[k] != '0 && rd_j[k] == jnt) begin
				hit  = 1'b1;
				hidx = SI_W'(k);
			end
		end
		lidx = '0;
		minw = rd_w[0];
		for (int k = 1; k < SLOTS; k++) begin
			if (rd_w[k] < minw) begin
				minw = rd_w[k];
				lidx = SI_W'(k);
			end
		end
		sumw = {1'b0, rd_w[hidx]} + (WEIGHT_W + 1)'(wnew);
		for (int k = 0; k < SLOTS; k++) begin
			aj[k] = rd_j[k];
			aw[k] = rd_w[k];
		end
		add_drop = 1'b0;
		if (wnew == '0) begin
			add_drop = 1'b1;
		end else if (hit) begin
			aw[hidx] = sumw[WEIGHT_W] ? WEIGHT_MAX : sumw[WEIGHT_W-1:0];
		end else if (wnew <= minw) begin
			add_drop = 1'b1;
		end else begin
			add_drop = (minw != '0);
			aj[lidx] = jnt;
			aw[lidx] = wnew;
		end
	end

	// normalise registers
	logic [JOINT_BITS-1:0] joints_q  [SLOTS];
	logic [WEIGHT_W-1:0]   weights_q [SLOTS];
	logic [SI_W-1:0]       idx_q;
	logic [TOT_W-1:0]      total_q;
	logic [TOT_W-1:0]      rem_q;
	logic [Q_BITS-1:0]     nsh_q;
	logic [Q_BITS-1:0]     quo_q;
	logic [BITCNT_W-1:0]   bit_q;

	logic [NUM_W-1:0]  num;
	logic [TOT_W:0]    trial;
	logic              ge;
	logic [TOT_W:0]    rem_n;
	logic [Q_BITS-1:0] quo_n;
	logic              last_slot;

	assign last_slot = (idx_q == SI_W'(SLOTS - 1));
	assign num   = NUM_W'({weights_q[idx_q], {FRAC_W{1'b0}}}) + NUM_W'(total_q >> 1);
	assign trial = {rem_q, nsh_q[Q_BITS-1]};
	assign ge    = trial >= {1'b0, total_q};
	assign rem_n = ge ? (trial - {1'b0, total_q}) : trial;
	assign quo_n = {quo_q[Q_BITS-2:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.norm_load) begin
			for (int k = 0; k < SLOTS; k++) begin
				joints_q[k]  <= rd_j[k];
				weights_q[k] <= rd_w[k];
			end
			total_q <= '0;
		end
		if (cmd.sum_step) begin
			total_q <= total_q + TOT_W'(weights_q[idx_q]);
		end
		if (cmd.div_init) begin
			rem_q <= TOT_W'(num[NUM_W-1:Q_BITS]);
			nsh_q <= num[Q_BITS-1:0];
			quo_q <= '0;
			bit_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_n[TOT_W-1:0];
			nsh_q <= {nsh_q[Q_BITS-2:0], 1'b0};
			quo_q <= quo_n;
			bit_q <= bit_q + 1'b1;
		end
		if (cmd.div_store) begin
			weights_q[idx_q] <= WEIGHT_W'(quo_n);
		end
		if (cmd.accept) begin
			item_q <= item;
			addr_q <= addr_in;
			inr_q  <= inr_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.norm_load) begin
				idx_q <= '0;
			end else if (cmd.sum_step || cmd.div_store) begin
				idx_q <= last_slot ? '0 : idx_q + 1'b1;
			end
			if (cmd.clr_write) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign sts.clear_last = (clr_q == VA'(VERTEX_COUNT - 1));
	assign sts.is_norm    = (item_q.op == OP_NORM) && inr_q;
	assign sts.slot_last  = last_slot;
	assign sts.total_zero = (total_q == '0);
	assign sts.div_last   = (bit_q == BITCNT_W'(Q_BITS - 1));

	// row shown / written
	logic [JOINT_BITS-1:0] sel_j [SLOTS];
	logic [WEIGHT_W-1:0]   sel_w [SLOTS];
	logic                  tbl_write;

	always_comb begin
		tbl_write = 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			sel_j[k] = joints_q[k];
			sel_w[k] = weights_q[k];
		end
		if (cmd.exec) begin
			case (item_q.op)
				OP_ADD: begin
					tbl_write = inr_q;
					for (int k = 0; k < SLOTS; k++) begin
						sel_j[k] = aj[k];
						sel_w[k] = aw[k];
					end
				end
				OP_CLEAR: begin
					tbl_write = inr_q;
					for (int k = 0; k < SLOTS; k++) begin
						sel_j[k] = '0;
						sel_w[k] = '0;
					end
				end
				default: begin
					for (int k = 0; k < SLOTS; k++) begin
						sel_j[k] = rd_j[k];
						sel_w[k] = rd_w[k];
					end
				end
			endcase
			if (!inr_q) begin
				for (int k = 0; k < SLOTS; k++) begin
					sel_j[k] = '0;
					sel_w[k] = '0;
				end
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		if (cmd.clr_write) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (tbl_write || cmd.norm_write) begin
			we = 1'b1;
			for (int k = 0; k < SLOTS; k++) begin
				wdata[k*SW +: SW] = {sel_j[k], sel_w[k]};
			end
		end
	end

	// discard counter and result register
	logic [31:0] disc_q, disc_d;
	logic        drop;
	logic        emit;
	logic [7:0]          shown_j [SHOWN];
	logic [WEIGHT_W-1:0] shown_w [SHOWN];

	assign drop   = cmd.exec && inr_q && (item_q.op == OP_ADD) && add_drop;
	assign disc_d = (drop && disc_q != COUNT_MAX) ? disc_q + 32'd1 : disc_q;
	assign emit   = cmd.exec || cmd.norm_write || cmd.bad_emit;

	always_comb begin
		for (int s = 0; s < SHOWN; s++) begin
			shown_j[s] = (s < SLOTS) ? 8'(sel_j[(s < SLOTS) ? s : 0]) : 8'd0;
			shown_w[s] = (s < SLOTS) ? sel_w[(s < SLOTS) ? s : 0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q <= '0;
			done   <= 1'b0;
		end else begin
			disc_q <= disc_d;
			done   <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.evicted_or_dropped <= drop;
			result.bad_total          <= cmd.bad_emit;
			result.discard_total      <= disc_d;
			result.joint_a            <= shown_j[0];
			result.joint_b            <= shown_j[1];
			result.joint_c            <= shown_j[2];
			result.joint_d            <= shown_j[3];
			result.weight_a           <= shown_w[0];
			result.weight_b           <= shown_w[1];
			result.weight_c           <= shown_w[2];
			result.weight_d           <= shown_w[3];
		end
	end

endmodule

[tb/sv/skin_influence_top4_normalize_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for skin_influence_top4_normalize: directed and random
// add, normalise, clear and unused ops against a behavioural vertex table.
// Depends on skinf_pkg and the skin_influence_top4_normalize RTL.
module skin_influence_top4_normalize_tb;
	import skinf_pkg::*;

	localparam int NVERT    = 4096;
	localparam int NSLOT    = 4;
	localparam int CYC_MAX  = 400000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	result_t result;
	logic    done;

	skin_influence_top4_normalize dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .result(result), .done(done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// behavioural copy of the vertex table
	logic [7:0]          tbl_joint [NVERT*NSLOT];
	logic [WEIGHT_W-1:0] tbl_weight[NVERT*NSLOT];
	logic [31:0]         drop_count;

	result_t entry_queue[$];
	int      n_errors = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      n_norm = 0;
	int      n_drops = 0;
	int      cycles = 0;
	bit      calm = 1'b0;       // no idle cycles while set

	function automatic void bump_drops();
		if (drop_count != COUNT_MAX)
			drop_count = drop_count + 1;
	endfunction

	// Work out the result of one transaction and update the table copy.
	function automatic result_t table_apply(item_t it);
		result_t r;
		int base, k, low, hit;
		logic [20:0] sum;
		logic [63:0] total, q;
		r = '0;
		if (it.vertex_id < NVERT) begin
			base = it.vertex_id * NSLOT;
			case (it.op)
				OP_ADD: begin
					hit = -1;
					if (it.weight == 0) begin
						bump_drops();
						r.evicted_or_dropped = 1'b1;
					end else begin
						for (k = 0; k < NSLOT; k++)
							if (hit < 0 && tbl_weight[base+k] != 0 &&
							    tbl_joint[base+k] == it.joint)
								hit = k;
						if (hit >= 0) begin
							sum = 21'(tbl_weight[base+hit]) + 21'(it.weight);
							tbl_weight[base+hit] = sum > WEIGHT_MAX ? WEIGHT_MAX : sum[19:0];
						end else begin
							low = 0;
							for (k = 1; k < NSLOT; k++)
								if (tbl_weight[base+k] < tbl_weight[base+low])
									low = k;
							if (it.weight <= tbl_weight[base+low]) begin
								bump_drops();
								r.evicted_or_dropped = 1'b1;
							end else begin
								if (tbl_weight[base+low] != 0) begin
									bump_drops();
									r.evicted_or_dropped = 1'b1;
								end
								tbl_joint[base+low]  = it.joint;
								tbl_weight[base+low] = WEIGHT_W'(it.weight);
							end
						end
					end
				end
				OP_NORM: begin
					total = 0;
					for (k = 0; k < NSLOT; k++)
						total += 64'(tbl_weight[base+k]);
					if (total == 0)
						r.bad_total = 1'b1;
					else
						for (k = 0; k < NSLOT; k++) begin
							q = (64'(tbl_weight[base+k]) * 65536 + total / 2) / total;
							tbl_weight[base+k] = q[19:0];
						end
				end
				OP_CLEAR: begin
					for (k = 0; k < NSLOT; k++) begin
						tbl_joint[base+k]  = '0;
						tbl_weight[base+k] = '0;
					end
				end
				default: ;
			endcase
			r.joint_a = tbl_joint[base];   r.weight_a = tbl_weight[base];
			r.joint_b = tbl_joint[base+1]; r.weight_b = tbl_weight[base+1];
			r.joint_c = tbl_joint[base+2]; r.weight_c = tbl_weight[base+2];
			r.joint_d = tbl_joint[base+3]; r.weight_d = tbl_weight[base+3];
		end
		r.discard_total = drop_count;
		return r;
	endfunction

	// One transaction: optional idle gap, then hold start until accepted.
	task automatic send_item(logic [1:0] op, int vid, int jnt, int wgt);
		item_t it;
		it.op = op;
		it.vertex_id = vid[VID_W-1:0];
		it.joint = jnt[7:0];
		it.weight = wgt[15:0];
		while (!calm && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		// accepted at this edge
		entry_queue = {entry_queue, table_apply(it)};
		if (it.op == OP_NORM)
			n_norm++;
		n_sent++;
	endtask

	// Result checker: done marks a single-cycle result, sampled at the edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (entry_queue.size() == 0) begin
				$display("%0t: result with nothing outstanding, actual %h", $time, result);
				n_errors++;
			end else begin
				result_t exp_r;
				exp_r = entry_queue.pop_front();
				n_checked++;
				if (exp_r.evicted_or_dropped) n_drops++;
				if (exp_r.evicted_or_dropped != result.evicted_or_dropped) begin
					$display("%0t: evicted_or_dropped exp %0d act %0d", $time,
					         exp_r.evicted_or_dropped, result.evicted_or_dropped);
					n_errors++;
				end
				if (exp_r.bad_total != result.bad_total) begin
					$display("%0t: bad_total exp %0d act %0d", $time,
					         exp_r.bad_total, result.bad_total);
					n_errors++;
				end
				if (exp_r.discard_total != result.discard_total) begin
					$display("%0t: discard_total exp %0d act %0d", $time,
					         exp_r.discard_total, result.discard_total);
					n_errors++;
				end
				if ({exp_r.joint_a, exp_r.joint_b, exp_r.joint_c, exp_r.joint_d} !=
				    {result.joint_a, result.joint_b, result.joint_c, result.joint_d}) begin
					$display("%0t: joints exp %h %h %h %h act %h %h %h %h", $time,
					         exp_r.joint_a, exp_r.joint_b, exp_r.joint_c, exp_r.joint_d,
					         result.joint_a, result.joint_b, result.joint_c, result.joint_d);
					n_errors++;
				end
				if ({exp_r.weight_a, exp_r.weight_b, exp_r.weight_c, exp_r.weight_d} !=
				    {result.weight_a, result.weight_b, result.weight_c,
				     result.weight_d}) begin
					$display("%0t: weights exp %h %h %h %h act %h %h %h %h", $time,
					         exp_r.weight_a, exp_r.weight_b, exp_r.weight_c, exp_r.weight_d,
					         result.weight_a, result.weight_b, result.weight_c,
					         result.weight_d);
					n_errors++;
				end
			end
		end
		if (cycles > CYC_MAX) begin
			$display("skin_influence_top4_normalize_tb: errors");
			$finish;
		end
	end

	// Edges of the fields, every op, and the special cases.
	task automatic test_directed();
		send_item(OP_NORM, 5, 0, 0);              // zero total
		send_item(OP_ADD, 5, 0, 0);               // zero weight dropped
		send_item(OP_ADD, 5, 8'hFF, 16'hFFFF);
		send_item(OP_ADD, 5, 8'hFF, 16'hFFFF);    // merge into same joint
		for (int i = 0; i < 15; i++)
			send_item(OP_ADD, 5, 8'hFF, 16'hFFFF);// saturate at 0xFFFFF
		send_item(OP_ADD, 5, 1, 100);
		send_item(OP_ADD, 5, 2, 100);
		send_item(OP_ADD, 5, 3, 50);
		send_item(OP_ADD, 5, 4, 50);              // not greater: dropped
		send_item(OP_ADD, 5, 4, 51);              // evicts slot with 50
		send_item(OP_NORM, 5, 0, 0);
		send_item(OP_SPARE, 5, 8'hAA, 16'h5555);  // unused op
		send_item(OP_CLEAR, 5, 0, 0);
		send_item(OP_ADD, 4095, 8'h55, 16'h0001);
		send_item(OP_NORM, 4095, 0, 0);
	endtask

	// Mostly adds into a small set of vertices so entries fill and evict.
	task automatic test_random(int count);
		int r, vid;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3) && (i < count / 3 + 120);
			vid = $urandom_range(15);
			if ($urandom_range(9) == 0) vid = $urandom_range(4095);
			r = $urandom_range(99);
			if (r < 78)
				send_item(OP_ADD, vid, $urandom_range(7) == 0 ? $urandom_range(255)
				          : $urandom_range(9),
				          $urandom_range(19) == 0 ? 0 : $urandom_range(65535));
			else if (r < 86)
				send_item(OP_NORM, vid, $urandom_range(255), $urandom_range(65535));
			else if (r < 94)
				send_item(OP_CLEAR, vid, $urandom_range(255), $urandom_range(65535));
			else
				send_item(OP_SPARE, vid, $urandom_range(255), $urandom_range(65535));
		end
		calm = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < NVERT*NSLOT; i++) begin
			tbl_joint[i] = '0;
			tbl_weight[i] = '0;
		end
		drop_count = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(930);
		start <= 1'b0;
		// wait for the last results, then a short settling window
		while (entry_queue.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		$display("Sent %0d transactions (%0d normalise), checked %0d results, %0d drops.",
		         n_sent, n_norm, n_checked, n_drops);
		if (n_errors == 0 && entry_queue.size() == 0)
			$display("skin_influence_top4_normalize_tb: clean");
		else
			$display("skin_influence_top4_normalize_tb: errors");
		$finish;
	end

endmodule

[skin_influence_top4_normalize.f]
sv/skinf_pkg.sv
sv/skinf_ram.sv
sv/skinf_ctrl.sv
sv/skinf_dp.sv
sv/skin_influence_top4_normalize.sv
tb/sv/skin_influence_top4_normalize_tb.sv
